### hw/rtl/csw_pkg.sv
package csw_pkg;

   localparam logic [1:0] CMD_LOAD_FIRST  = 2'd0;
   localparam logic [1:0] CMD_LOAD_SECOND = 2'd1;
   localparam logic [1:0] CMD_COMPUTE     = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_WINDOW   = 2'd1;
   localparam logic [1:0] ST_NEGATIVE = 2'd2;

   localparam logic signed [63:0] COST_INF = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] COST_MIN = 64'sh8000_0000_0000_0000;
   localparam logic [31:0]        DIST_INF = 32'hFFFF_FFFF;
   localparam logic [23:0]        TIME_MAX = 24'hFF_FFFF;

   typedef enum logic [2:0] {
      MUL_DIFF,
      MUL_AA,
      MUL_BB,
      MUL_BAA,
      MUL_ABB
   } mul_sel_type;

   typedef struct packed {
      logic              run;
      logic [23:0]       tstamp;
      logic signed [15:0] val;
   } elem_type;

   typedef struct packed {
      logic        load_first;
      logic        load_second;
      logic        start;
      logic        check;
      logic        rd_row;
      logic        rd_col;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        add;
      logic        commit;
      logic        root_init;
      logic        root_step;
      logic        out_load;
   } csw_cmd_type;

   typedef struct packed {
      logic too_small;
      logic last_col;
      logic last_row;
      logic fin_inf;
      logic fin_neg;
      logic root_done;
      logic empty;
   } csw_stat_type;

endpackage

### hw/rtl/csw_dp.sv
module csw_dp import csw_pkg::*; #(
   parameter int MAX_LEN = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  csw_cmd_type        cmd,
   output csw_stat_type       stat,
   input  logic signed [15:0] req_value,
   input  logic               req_is_run,
   input  logic               csr_wr_en,
   input  logic [15:0]        csr_wr_data,
   output logic [31:0]        out_distance,
   output logic               out_unreachable,
   output logic [1:0]         out_status
);

   localparam int AW = $clog2(MAX_LEN);
   localparam int CW = $clog2(MAX_LEN + 1);

   function automatic logic [23:0] time_adv(input logic [23:0] acc,
                                            input logic signed [15:0] v);
      logic [16:0] step;
      logic [24:0] sum;
      step = (v > 16'sd0) ? 17'd1 : 17'(-(17'(v)));
      sum  = {1'b0, acc} + {8'd0, step};
      return sum[24] ? TIME_MAX : sum[23:0];
   endfunction

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] x,
                                                  input logic signed [63:0] y);
      logic signed [64:0] s;
      s = 65'(x) + 65'(y);
      if (x == COST_INF || y == COST_INF) return COST_INF;
      else if (s[64] != s[63]) return s[64] ? COST_MIN : COST_INF;
      else return s[63:0];
   endfunction

   elem_type           fir_mem [MAX_LEN];
   elem_type           sec_mem [MAX_LEN];
   logic signed [63:0] cost_mem [MAX_LEN];

   logic [CW-1:0] fcnt_ff, scnt_ff, ns_ff, nt_ff, diff;
   logic [23:0]   facc_ff, sacc_ff, facc_in, sacc_in;
   logic [15:0]   win_ff;
   logic          ffree, sfree;

   logic [AW-1:0] i_ff, j_ff;
   elem_type      fir_q_ff, sec_q_ff;
   logic signed [63:0] cost_q_ff, diag_ff, left_ff, fin_ff, up;
   logic [23:0]   prev_ta_ff, prev_tb_ff;
   logic          tsmall_ff, i0, j0;

   logic signed [16:0] dab, mx;
   logic signed [32:0] my;
   logic signed [49:0] prod, m1_ff, m2_ff, m3_ff, m4_ff, m5_ff;

   logic signed [63:0] cd, cl, ct, d1_ff, d2_ff, d3_ff, m12, node_cost;
   logic [23:0]   ta, tb, gap;
   logic          far, cut;

   logic [63:0]   rad_ff;
   logic [33:0]   rem_ff;
   logic [31:0]   root_ff;
   logic [4:0]    sq_cnt_ff;
   logic [35:0]   rem_in, trial;
   logic          ge;

   logic [31:0]   dist_ff;
   logic          unr_ff;
   logic [1:0]    st_ff;

   assign ffree   = fcnt_ff < CW'(MAX_LEN);
   assign sfree   = scnt_ff < CW'(MAX_LEN);
   assign facc_in = time_adv(facc_ff, req_value);
   assign sacc_in = time_adv(sacc_ff, req_value);
   assign diff    = (ns_ff > nt_ff) ? ns_ff - nt_ff : nt_ff - ns_ff;
   assign i0      = i_ff == '0;
   assign j0      = j_ff == '0;

   assign stat.too_small = win_ff < 16'(diff);
   assign stat.last_col  = CW'(j_ff) + CW'(1) == nt_ff;
   assign stat.last_row  = CW'(i_ff) + CW'(1) == ns_ff;
   assign stat.fin_inf   = fin_ff == COST_INF;
   assign stat.fin_neg   = fin_ff[63];
   assign stat.root_done = sq_cnt_ff == 5'd31;
   assign stat.empty     = ns_ff == '0 || nt_ff == '0;

   // counts, time accumulators, window
   always_ff @(posedge clock) begin
      if (reset) begin
         fcnt_ff <= '0;
         scnt_ff <= '0;
         facc_ff <= '0;
         sacc_ff <= '0;
         win_ff  <= '0;
      end else begin
         if (csr_wr_en) win_ff <= csr_wr_data;
         if (cmd.load_first && ffree) begin
            fcnt_ff <= fcnt_ff + CW'(1);
            facc_ff <= facc_in;
         end
         if (cmd.load_second && sfree) begin
            scnt_ff <= scnt_ff + CW'(1);
            sacc_ff <= sacc_in;
         end
         if (cmd.start) begin
            fcnt_ff <= '0;
            scnt_ff <= '0;
            facc_ff <= '0;
            sacc_ff <= '0;
         end
      end
   end

   // element and row memories
   always_ff @(posedge clock) begin
      if (cmd.load_first && ffree)
         fir_mem[fcnt_ff[AW-1:0]] <= '{run: req_is_run, tstamp: facc_in, val: req_value};
      if (cmd.load_second && sfree)
         sec_mem[scnt_ff[AW-1:0]] <= '{run: req_is_run, tstamp: sacc_in, val: req_value};
      if (cmd.rd_row) fir_q_ff <= fir_mem[i_ff];
      if (cmd.rd_col) begin
         sec_q_ff  <= sec_mem[j_ff];
         cost_q_ff <= cost_mem[j_ff];
      end
      if (cmd.commit) cost_mem[j_ff] <= node_cost;
   end

   // shared multiplier
   assign dab = 17'($signed(fir_q_ff.val)) - 17'($signed(sec_q_ff.val));

   always_comb begin
      case (cmd.mul_sel)
         MUL_DIFF: begin
            mx = dab;
            my = 33'(dab);
         end
         MUL_AA: begin
            mx = 17'($signed(fir_q_ff.val));
            my = 33'($signed(fir_q_ff.val));
         end
         MUL_BB: begin
            mx = 17'($signed(sec_q_ff.val));
            my = 33'($signed(sec_q_ff.val));
         end
         MUL_BAA: begin
            mx = 17'($signed(sec_q_ff.val));
            my = $signed(m2_ff[32:0]);
         end
         MUL_ABB: begin
            mx = 17'($signed(fir_q_ff.val));
            my = $signed(m3_ff[32:0]);
         end
         default: begin
            mx = '0;
            my = '0;
         end
      endcase
   end

   assign prod = mx * my;

   // move costs
   assign ta  = fir_q_ff.tstamp;
   assign tb  = sec_q_ff.tstamp;
   assign gap = (ta > tb) ? ta - tb : tb - ta;
   assign far = gap > {8'd0, win_ff};
   assign cut = far &&
      ((!j0 && {1'b0, prev_tb_ff} > {1'b0, ta} + {9'd0, win_ff}) ||
       (!i0 && {1'b0, prev_ta_ff} > {1'b0, tb} + {9'd0, win_ff}));
   assign up  = i0 ? COST_INF : cost_q_ff;

   always_comb begin
      logic ra, rb, ee, rr, er, re;
      logic signed [63:0] sq;
      ra = fir_q_ff.run;
      rb = sec_q_ff.run;
      ee = !ra && !rb;
      rr = ra && rb;
      er = !ra && rb;
      re = ra && !rb;
      sq = 64'(m1_ff);
      if (i0 || j0)       cd = sq;
      else if (ee && !far) cd = sq;
      else if (rr)        cd = '0;
      else if (er)        cd = 64'(m4_ff);
      else if (re)        cd = 64'(m5_ff);
      else                cd = COST_INF;
      if (ee && !far)      cl = sq;
      else if (rr)         cl = '0;
      else if (er && !far) cl = 64'(m4_ff);
      else if (re)         cl = 64'(m3_ff);
      else                 cl = COST_INF;
      if (ee && !far)      ct = sq;
      else if (rr)         ct = '0;
      else if (er)         ct = 64'(m2_ff);
      else if (re && !far) ct = 64'(m5_ff);
      else                 ct = COST_INF;
   end

   assign m12       = (d1_ff < d2_ff) ? d1_ff : d2_ff;
   assign node_cost = cut ? COST_INF : ((d3_ff < m12) ? d3_ff : m12);

   // root step
   assign rem_in = {rem_ff, rad_ff[63:62]};
   assign trial  = {2'b00, root_ff, 2'b01};
   assign ge     = rem_in >= trial;

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         ns_ff <= fcnt_ff;
         nt_ff <= scnt_ff;
      end
      if (cmd.check) begin
         tsmall_ff <= stat.too_small;
         fin_ff    <= (ns_ff == '0 && nt_ff == '0) ? '0 : COST_INF;
         i_ff      <= '0;
         j_ff      <= '0;
      end
      if (cmd.rd_row) begin
         diag_ff    <= i0 ? '0 : COST_INF;
         left_ff    <= COST_INF;
         prev_ta_ff <= fir_q_ff.tstamp;
      end
      if (cmd.mul_en) begin
         case (cmd.mul_sel)
            MUL_DIFF: m1_ff <= prod;
            MUL_AA:   m2_ff <= prod;
            MUL_BB:   m3_ff <= prod;
            MUL_BAA:  m4_ff <= prod;
            MUL_ABB:  m5_ff <= prod;
            default: ;
         endcase
      end
      if (cmd.add) begin
         d1_ff <= sat_add(diag_ff, cd);
         d2_ff <= sat_add(left_ff, cl);
         d3_ff <= sat_add(up, ct);
      end
      if (cmd.commit) begin
         left_ff    <= node_cost;
         diag_ff    <= up;
         prev_tb_ff <= tb;
         fin_ff     <= node_cost;
         if (stat.last_col) begin
            j_ff <= '0;
            i_ff <= i_ff + AW'(1);
         end else begin
            j_ff <= j_ff + AW'(1);
         end
      end
      if (cmd.root_init) begin
         rad_ff    <= fin_ff;
         rem_ff    <= '0;
         root_ff   <= '0;
         sq_cnt_ff <= '0;
      end
      if (cmd.root_step) begin
         rem_ff    <= ge ? 34'(rem_in - trial) : rem_in[33:0];
         root_ff   <= {root_ff[30:0], ge};
         rad_ff    <= {rad_ff[61:0], 2'b00};
         sq_cnt_ff <= sq_cnt_ff + 5'd1;
      end
      if (cmd.out_load) begin
         if (tsmall_ff) begin
            dist_ff <= '0;
            unr_ff  <= 1'b0;
            st_ff   <= ST_WINDOW;
         end else if (stat.fin_inf) begin
            dist_ff <= DIST_INF;
            unr_ff  <= 1'b1;
            st_ff   <= ST_OK;
         end else if (stat.fin_neg) begin
            dist_ff <= '0;
            unr_ff  <= 1'b0;
            st_ff   <= ST_NEGATIVE;
         end else begin
            dist_ff <= root_ff;
            unr_ff  <= 1'b0;
            st_ff   <= ST_OK;
         end
      end
   end

   assign out_distance    = dist_ff;
   assign out_unreachable = unr_ff;
   assign out_status      = st_ff;

endmodule

### hw/rtl/csw_ctrl.sv
module csw_ctrl import csw_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic [1:0]   req_cmd,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output csw_cmd_type  cmd,
   input  csw_stat_type stat
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_ROW,
      S_COL,
      S_MDIFF,
      S_MAA,
      S_MBB,
      S_MBAA,
      S_MABB,
      S_ADD,
      S_MIN,
      S_ROOT_INIT,
      S_SQRT,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_tvalid_ff;
   logic      out_free;

   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && !reset;
   assign rsp_tvalid = rsp_tvalid_ff;

   always_comb begin
      cmd         = '0;
      cmd.mul_sel = MUL_DIFF;
      state_in    = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && !reset) begin
               case (req_cmd)
                  CMD_LOAD_FIRST:  cmd.load_first  = 1'b1;
                  CMD_LOAD_SECOND: cmd.load_second = 1'b1;
                  CMD_COMPUTE: begin
                     cmd.start = 1'b1;
                     state_in  = S_CHECK;
                  end
                  default: ;
               endcase
            end
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            if (stat.too_small)  state_in = S_DONE;
            else if (stat.empty) state_in = S_ROOT_INIT;
            else                 state_in = S_ROW;
         end
         S_ROW: begin
            cmd.rd_row = 1'b1;
            state_in   = S_COL;
         end
         S_COL: begin
            cmd.rd_col = 1'b1;
            state_in   = S_MDIFF;
         end
         S_MDIFF: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_DIFF;
            state_in    = S_MAA;
         end
         S_MAA: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_AA;
            state_in    = S_MBB;
         end
         S_MBB: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_BB;
            state_in    = S_MBAA;
         end
         S_MBAA: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_BAA;
            state_in    = S_MABB;
         end
         S_MABB: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_ABB;
            state_in    = S_ADD;
         end
         S_ADD: begin
            cmd.add  = 1'b1;
            state_in = S_MIN;
         end
         S_MIN: begin
            cmd.commit = 1'b1;
            if (!stat.last_col)     state_in = S_COL;
            else if (stat.last_row) state_in = S_ROOT_INIT;
            else                    state_in = S_ROW;
         end
         S_ROOT_INIT: begin
            cmd.root_init = 1'b1;
            state_in      = S_SQRT;
         end
         S_SQRT: begin
            cmd.root_step = 1'b1;
            if (stat.root_done) state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.out_load) rsp_tvalid_ff <= 1'b1;
         else if (rsp_tready) rsp_tvalid_ff <= 1'b0;
      end
   end

endmodule

### hw/rtl/constrained_sparse_warp_distance_core.sv
// channel   direction  contents
// req       in         tdata: value[15:0]; tuser: cmd[1:0], is_run[2]
// rsp       out        tdata: distance[31:0]; tuser: unreachable[0], status[2:1]
// csr       in         csr_wr_data: window[15:0], written when csr_wr_en is high
//
// a load word is taken while idle; a compute word holds the input while it runs: a
// row read per row; per cell a column read, five products on the shared multiplier,
// sums, minimum; 32 root steps; only root steps if empty, none if window too narrow
// reset clears counts, time accumulators, window and the controller
// a finished result waits in the output register while loads are taken; the next
// compute stalls in its last cycle until that register is free
module constrained_sparse_warp_distance_core import csw_pkg::*; #(
   parameter int MAX_LEN = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // value
   input  logic [2:0]  req_tuser,   // cmd, is_run
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // distance
   output logic [2:0]  rsp_tuser,   // unreachable, status
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   csw_cmd_type  cmd;
   csw_stat_type stat;

   csw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_cmd    (req_tuser[1:0]),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   csw_dp #(
      .MAX_LEN (MAX_LEN)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_value       ($signed(req_tdata)),
      .req_is_run      (req_tuser[2]),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .out_distance    (rsp_tdata),
      .out_unreachable (rsp_tuser[0]),
      .out_status      (rsp_tuser[2:1])
   );

endmodule

### test/constrained_sparse_warp_distance_checker.sv
`timescale 1ns / 100ps

module constrained_sparse_warp_distance_checker import csw_pkg::*; #(
   parameter int MAX_LEN = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,   // value
   input  logic [2:0]  req_tuser,   // cmd, is_run
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // distance
   input  logic [2:0]  rsp_tuser,   // unreachable, status
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   output int          errors,
   output int          outstanding
);

   typedef enum int {STEP_DIAG, STEP_LEFT, STEP_TOP} step_kind_type;

   typedef struct {
      logic signed [15:0] val;
      logic               run;
      logic [23:0]        tstamp;
   } element_rec_type;

   typedef struct {
      logic [31:0] distance;
      logic        unreachable;
      logic [1:0]  status;
   } distance_rec_type;

   element_rec_type  first_series[MAX_LEN];
   element_rec_type  second_series[MAX_LEN];
   int               first_len, second_len;
   logic [23:0]      first_clock_acc, second_clock_acc;
   logic [15:0]      window_reg;
   distance_rec_type expected_distances[$];

   assign outstanding = expected_distances.size();

   function automatic longint cost_sum(longint x, longint y);
      if (x == COST_INF || y == COST_INF) return COST_INF;
      if (y > 0 && x > COST_INF - y) return COST_INF;
      if (y < 0 && x < COST_MIN - y) return COST_MIN;
      return x + y;
   endfunction

   function automatic longint step_cost(longint a, longint b, step_kind_type kind, logic ra,
                                        logic rb, longint gap);
      bit near_enough;
      near_enough = gap <= longint'(window_reg);
      if (!ra && !rb && near_enough) return (a - b) * (a - b);
      if (ra && rb) return 0;
      case (kind)
         STEP_DIAG: begin
            if (!ra && rb) return b * (a * a);
            if (ra && !rb) return a * (b * b);
         end
         STEP_LEFT: begin
            if (!ra && rb && near_enough) return b * (a * a);
            if (ra && !rb) return b * b;
         end
         default: begin
            if (!ra && rb) return a * a;
            if (ra && !rb && near_enough) return a * (b * b);
         end
      endcase
      return COST_INF;
   endfunction

   function automatic logic [31:0] root_floor(longint unsigned v);
      longint unsigned res, probe;
      res = 0;
      probe = 64'd1 << 62;
      while (probe > v) probe >>= 2;
      while (probe != 0) begin
         if (v >= res + probe) begin
            v -= res + probe;
            res = (res >> 1) + probe;
         end else begin
            res >>= 1;
         end
         probe >>= 2;
      end
      return res[31:0];
   endfunction

   function automatic longint warp_cost(int ns, int nt);
      longint row[MAX_LEN+1];
      longint diag, up, left, a, b, ta, tb, w, gap, node_cost, d1, d2, d3;
      logic ra, rb;
      bit cut;
      w = longint'(window_reg);
      row[0] = 0;
      for (int j = 1; j <= nt; j++) row[j] = COST_INF;
      for (int i = 0; i < ns; i++) begin
         diag = row[0];
         a = first_series[i].val;
         ta = first_series[i].tstamp;
         ra = first_series[i].run;
         row[0] = COST_INF;
         for (int j = 0; j < nt; j++) begin
            up = row[j+1];
            left = row[j];
            b = second_series[j].val;
            tb = second_series[j].tstamp;
            rb = second_series[j].run;
            gap = ta > tb ? ta - tb : tb - ta;
            cut = gap > w &&
                  ((j > 0 && longint'(second_series[j-1].tstamp) - ta > w) ||
                   (i > 0 && longint'(first_series[i-1].tstamp) - tb > w));
            if (cut) begin
               node_cost = COST_INF;
            end else begin
               if (i > 0 && j > 0) d1 = cost_sum(diag, step_cost(a, b, STEP_DIAG, ra, rb, gap));
               else d1 = cost_sum(diag, (a - b) * (a - b));
               d2 = cost_sum(left, step_cost(a, b, STEP_LEFT, ra, rb, gap));
               d3 = cost_sum(up, step_cost(a, b, STEP_TOP, ra, rb, gap));
               node_cost = d1 < d2 ? d1 : d2;
               if (d3 < node_cost) node_cost = d3;
            end
            diag = up;
            row[j+1] = node_cost;
         end
      end
      return row[nt];
   endfunction

   function automatic logic [23:0] clock_advance(logic [23:0] acc, logic signed [15:0] v);
      int unsigned next;
      next = acc + (v > 0 ? 1 : -int'(v));
      return next > TIME_MAX ? TIME_MAX : next[23:0];
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      if (errors < 100) $display("mismatch on %s: got %0d, expected %0d", field, got, want);
      errors++;
   endtask

   task automatic take_word(logic [1:0] cmd, logic signed [15:0] v, logic run);
      distance_rec_type r;
      int diff;
      longint fin;
      case (cmd)
         CMD_LOAD_FIRST: begin
            if (first_len < MAX_LEN) begin
               first_clock_acc = clock_advance(first_clock_acc, v);
               first_series[first_len] = '{v, run, first_clock_acc};
               first_len++;
            end
         end
         CMD_LOAD_SECOND: begin
            if (second_len < MAX_LEN) begin
               second_clock_acc = clock_advance(second_clock_acc, v);
               second_series[second_len] = '{v, run, second_clock_acc};
               second_len++;
            end
         end
         CMD_COMPUTE: begin
            r = '{32'd0, 1'b0, ST_OK};
            diff = first_len > second_len ? first_len - second_len : second_len - first_len;
            if (int'(window_reg) < diff) begin
               r.status = ST_WINDOW;
            end else begin
               fin = warp_cost(first_len, second_len);
               if (fin == COST_INF) r = '{DIST_INF, 1'b1, ST_OK};
               else if (fin < 0) r.status = ST_NEGATIVE;
               else r.distance = root_floor(fin);
            end
            expected_distances.push_back(r);
            first_len = 0;
            second_len = 0;
            first_clock_acc = '0;
            second_clock_acc = '0;
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      distance_rec_type want;
      if (reset) begin
         first_len = 0;
         second_len = 0;
         first_clock_acc = '0;
         second_clock_acc = '0;
         window_reg = '0;
         errors = 0;
         expected_distances.delete();
      end else begin
         if (csr_wr_en) window_reg = csr_wr_data;
         if (req_tvalid && req_tready) take_word(req_tuser[1:0], req_tdata, req_tuser[2]);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_distances.size() == 0) begin
               report_mismatch("unexpected result word", rsp_tdata, 0);
            end else begin
               want = expected_distances.pop_front();
               if (rsp_tdata !== want.distance)
                  report_mismatch("distance", rsp_tdata, want.distance);
               if (rsp_tuser[0] !== want.unreachable)
                  report_mismatch("unreachable", rsp_tuser[0], want.unreachable);
               if (rsp_tuser[2:1] !== want.status)
                  report_mismatch("status", rsp_tuser[2:1], want.status);
            end
         end
      end
   end

endmodule

### test/constrained_sparse_warp_distance_core_tb.sv
`timescale 1ns / 100ps

module constrained_sparse_warp_distance_core_tb import csw_pkg::*;;

   localparam int IDLE_LIMIT = 200000;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid, req_tready;
   logic [15:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid, rsp_tready;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;
   int          errors, outstanding;
   int          sent_words, idle_cycles;
   bit          gaps_on, hold_now;

   constrained_sparse_warp_distance_core uut (.*);

   constrained_sparse_warp_distance_checker watcher (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // result side, with the long hold-off when asked for
   initial begin
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_now) begin
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_now = 1'b0;
         end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic send_word(logic [1:0] cmd, logic [15:0] v, logic run);
      if (gaps_on && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= v;
      req_tuser <= {run, cmd};
      do @(posedge clock); while (!req_tready);
      sent_words++;
   endtask

   task automatic set_window(logic [15:0] w);
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (outstanding == 0);
      repeat (10) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= w;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [15:0] pick_value(logic run);
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1: return run ? -16'($urandom_range(0, 8)) : 16'($urandom_range(1, 40));
         2: return 16'($signed($urandom_range(0, 60)) - 30);
         default: return run ? -16'($urandom_range(0, 3)) : 16'($urandom_range(1, 9));
      endcase
   endfunction

   task automatic send_series_pair;
      int nf, ns;
      logic run;
      nf = $urandom_range(0, 9) == 0 ? $urandom_range(13, 16) : $urandom_range(0, 8);
      ns = $urandom_range(0, 9) == 0 ? $urandom_range(13, 16) : $urandom_range(0, 8);
      while (nf + ns > 0) begin
         run = $urandom_range(0, 1);
         if ($urandom_range(0, 19) == 0) begin
            send_word(2'($urandom_range(0, 3)) | 2'b01, 16'($urandom), run);
         end else if (nf > 0 && (ns == 0 || $urandom_range(0, 1))) begin
            send_word(CMD_LOAD_FIRST, pick_value(run), run);
            nf--;
         end else begin
            send_word(CMD_LOAD_SECOND, pick_value(run), run);
            ns--;
         end
      end
      send_word(CMD_COMPUTE, 16'($urandom), $urandom_range(0, 1));
   endtask

   initial begin
      logic [15:0] w;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= '0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      sent_words = 0;
      gaps_on = 1'b1;
      hold_now = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      set_window(16'd0);
      send_word(CMD_COMPUTE, 16'h0000, 1'b0);
      send_word(CMD_LOAD_FIRST, 16'h0003, 1'b0);
      send_word(CMD_COMPUTE, 16'hFFFF, 1'b1);
      set_window(16'hFFFF);
      send_word(CMD_LOAD_FIRST, 16'h7FFF, 1'b0);
      send_word(CMD_LOAD_FIRST, 16'h8000, 1'b1);
      send_word(CMD_LOAD_FIRST, 16'h0000, 1'b1);
      send_word(CMD_LOAD_SECOND, 16'h8000, 1'b0);
      send_word(CMD_LOAD_SECOND, 16'h0005, 1'b0);
      send_word(CMD_LOAD_SECOND, 16'h7FFF, 1'b1);
      send_word(CMD_COMPUTE, 16'h0000, 1'b0);
      send_word(CMD_LOAD_FIRST, 16'd100, 1'b0);
      send_word(CMD_LOAD_FIRST, 16'd7, 1'b0);
      send_word(CMD_LOAD_SECOND, -16'd5, 1'b1);
      send_word(CMD_LOAD_SECOND, -16'd2, 1'b1);
      send_word(2'd3, 16'h1234, 1'b1);
      send_word(CMD_COMPUTE, 16'h0000, 1'b0);
      send_word(CMD_LOAD_SECOND, 16'd3, 1'b0);
      send_word(CMD_COMPUTE, 16'h0000, 1'b0);

      // one series overfilled, the other left empty
      for (int k = 0; k < 257; k++) begin
         logic run;
         run = $urandom_range(0, 1);
         send_word(CMD_LOAD_FIRST, pick_value(run), run);
      end
      send_word(CMD_COMPUTE, 16'h0000, 1'b0);

      set_window(16'd3);
      hold_now = 1'b1;
      repeat (6) send_series_pair();

      while (sent_words < 1600) begin
         case ($urandom_range(0, 5))
            0: w = 16'd0;
            1: w = 16'hFFFF;
            2: w = 16'($urandom);
            default: w = 16'($urandom_range(1, 40));
         endcase
         set_window(w);
         if (sent_words > 1400) gaps_on = 1'b0;
         repeat ($urandom_range(2, 6)) send_series_pair();
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (outstanding == 0);
      repeat (50) @(posedge clock);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
